### rtl/core/range_max_count_tree_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the range maximum tree
// Shared concurrent assertion forms, clocked and held off during reset.
// ----------------------------------------------------------------------------
`ifndef RANGE_MAX_COUNT_TREE_MACROS_SVH
`define RANGE_MAX_COUNT_TREE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RMCT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RMCT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/rmct_pkg.sv
// ----------------------------------------------------------------------------
// Range maximum tree package
// Beat types, tree node type and sequencer states.
// ----------------------------------------------------------------------------
package rmct_pkg;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   typedef struct packed {
      logic        mode;
      logic [9:0]  position;
      logic [30:0] value;
      logic [9:0]  query_left;
      logic [9:0]  query_right;
   } req_type;

   typedef struct packed {
      logic signed [31:0] max_value;
      logic [10:0]        max_count;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] maximum;
      logic [10:0]        tally;
   } node_type;

   localparam node_type EMPTY_NODE = '{maximum: -32'sd1, tally: 11'd0};

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WR_LEAF,
      ST_WR_READ,
      ST_WR_MERGE,
      ST_Q_START,
      ST_Q_TEST_A,
      ST_Q_ACC_A,
      ST_Q_TEST_B,
      ST_Q_ACC_B,
      ST_RESP
   } state_type;

endpackage

### rtl/core/rmct_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module rmct_ram #(
   parameter int WIDTH = 43,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/range_max_count_tree.sv
// ----------------------------------------------------------------------------
// Range maximum tree with count
// Segment tree over CAPACITY elements giving the maximum of a range and how
// many elements reach it.
// ----------------------------------------------------------------------------
// The tree lives in one RAM of 2*L nodes, where L is CAPACITY rounded up to a
// power of two. After reset the block sweeps the RAM to empty nodes, one node
// a cycle, before it takes the first beat. A write beat stores the leaf, then
// reads each sibling and writes each parent on the way to the root, one RAM
// read and one merge per step. A query beat goes straight to its response for
// an empty range; otherwise each tree level costs one test step per boundary
// plus one merge step for each node read.
// The block takes one beat at a time and accepts the next beat while a result
// still waits on the response channel.
module range_max_count_tree #(
   parameter int CAPACITY = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rmct_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rmct_pkg::rsp_type rsp_data
);

   import rmct_pkg::*;

`include "range_max_count_tree_macros.svh"

   localparam int LEAF_BITS = $clog2(CAPACITY);
   localparam int LEAVES    = 1 << LEAF_BITS;
   localparam int NODE_BITS = LEAF_BITS + 1;
   localparam int IDX_W     = LEAF_BITS + 2;
   localparam int DEPTH     = 2 * LEAVES;
   localparam int NODE_W    = $bits(node_type);

   state_type            state_ff, state_in;
   req_type              req_ff, req_in;
   node_type             acc_ff, acc_in;
   logic [NODE_BITS-1:0] node_ff, node_in;
   logic [NODE_BITS-1:0] clr_ff, clr_in;
   logic [IDX_W-1:0]     a_ff, a_in;
   logic [IDX_W-1:0]     b_ff, b_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 ram_we;
   logic [NODE_BITS-1:0] ram_waddr;
   node_type             ram_wdata;
   logic [NODE_BITS-1:0] ram_raddr;
   logic [NODE_W-1:0]    ram_rdata;
   node_type             rd_node;
   node_type             merged;

   logic                 req_fire;
   logic                 rsp_load;
   logic                 slot_free;
   logic [31:0]          pos_wide;
   logic [31:0]          lo_wide;
   logic [31:0]          hi_wide;
   logic                 pos_bad;
   logic                 range_empty;
   logic [NODE_BITS-1:0] parent;
   logic                 is_query;
   logic                 q_walk;
   logic                 q_busy;

   function automatic node_type merge_nodes(node_type x, node_type y);
      node_type r;
      r = x;
      if (y.maximum > x.maximum) begin
         r = y;
      end else if (y.maximum == x.maximum) begin
         r.tally = x.tally + y.tally;
      end
      return r;
   endfunction

   rmct_ram #(
      .WIDTH (NODE_W),
      .DEPTH (DEPTH)
   ) u_tree_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rd_node   = node_type'(ram_rdata);
   assign merged    = merge_nodes(acc_ff, rd_node);
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_load  = (state_ff == ST_RESP) && slot_free;
   assign parent    = node_ff >> 1;

   assign pos_wide    = 32'(req_ff.position);
   assign lo_wide     = 32'(req_ff.query_left);
   assign pos_bad     = pos_wide >= 32'(CAPACITY);
   assign hi_wide     = (32'(req_ff.query_right) >= 32'(CAPACITY)) ?
                        32'(CAPACITY - 1) : 32'(req_ff.query_right);
   assign range_empty = lo_wide > hi_wide;

   assign is_query = (req_ff.mode == MODE_QUERY);
   assign q_walk   = (state_ff == ST_Q_TEST_A) || (state_ff == ST_Q_ACC_A) ||
                     (state_ff == ST_Q_TEST_B) || (state_ff == ST_Q_ACC_B);
   assign q_busy   = q_walk || (state_ff == ST_Q_START) || (state_ff == ST_RESP);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (req_data.mode == MODE_QUERY) ? ST_Q_START : ST_WR_LEAF;
            end
         end
         ST_WR_LEAF: begin
            state_in = pos_bad ? ST_IDLE : ST_WR_READ;
         end
         ST_WR_READ: begin
            state_in = ST_WR_MERGE;
         end
         ST_WR_MERGE: begin
            state_in = (parent == NODE_BITS'(1)) ? ST_IDLE : ST_WR_READ;
         end
         ST_Q_START: begin
            state_in = range_empty ? ST_RESP : ST_Q_TEST_A;
         end
         ST_Q_TEST_A: begin
            if (a_ff >= b_ff) begin
               state_in = ST_RESP;
            end else if (a_ff[0]) begin
               state_in = ST_Q_ACC_A;
            end else begin
               state_in = ST_Q_TEST_B;
            end
         end
         ST_Q_ACC_A: begin
            state_in = ST_Q_TEST_B;
         end
         ST_Q_TEST_B: begin
            state_in = b_ff[0] ? ST_Q_ACC_B : ST_Q_TEST_A;
         end
         ST_Q_ACC_B: begin
            state_in = ST_Q_TEST_A;
         end
         ST_RESP: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      req_in    = req_ff;
      acc_in    = acc_ff;
      node_in   = node_ff;
      clr_in    = clr_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      ram_we    = 1'b0;
      ram_waddr = node_ff;
      ram_wdata = merged;
      ram_raddr = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = EMPTY_NODE;
            clr_in    = clr_ff + NODE_BITS'(1);
         end
         ST_IDLE: begin
            if (req_fire) begin
               req_in = req_data;
            end
         end
         ST_WR_LEAF: begin
            node_in   = NODE_BITS'(LEAVES) + NODE_BITS'(pos_wide);
            acc_in    = '{maximum: signed'({1'b0, req_ff.value}), tally: 11'd1};
            ram_waddr = node_in;
            ram_wdata = acc_in;
            ram_we    = !pos_bad;
         end
         ST_WR_READ: begin
            ram_raddr = node_ff ^ NODE_BITS'(1);
         end
         ST_WR_MERGE: begin
            ram_we    = 1'b1;
            ram_waddr = parent;
            ram_wdata = merged;
            acc_in    = merged;
            node_in   = parent;
         end
         ST_Q_START: begin
            acc_in = EMPTY_NODE;
            a_in   = IDX_W'(LEAVES) + IDX_W'(lo_wide);
            b_in   = IDX_W'(LEAVES) + IDX_W'(hi_wide) + IDX_W'(1);
         end
         ST_Q_TEST_A: begin
            if ((a_ff < b_ff) && a_ff[0]) begin
               ram_raddr = a_ff[NODE_BITS-1:0];
               a_in      = a_ff + IDX_W'(1);
            end
         end
         ST_Q_ACC_A: begin
            acc_in = merged;
         end
         ST_Q_TEST_B: begin
            if (b_ff[0]) begin
               b_in      = b_ff - IDX_W'(1);
               ram_raddr = b_in[NODE_BITS-1:0];
            end else begin
               a_in = a_ff >> 1;
               b_in = b_ff >> 1;
            end
         end
         ST_Q_ACC_B: begin
            acc_in = merged;
            a_in   = a_ff >> 1;
            b_in   = b_ff >> 1;
         end
         ST_RESP: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (rsp_load) begin
         rsp_in       = '{max_value: acc_ff.maximum, max_count: acc_ff.tally};
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      acc_ff  <= acc_in;
      node_ff <= node_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `RMCT_ASSERT_SAME(a_only_queries_respond, clock, reset, rsp_load, is_query, "write answered")
   `RMCT_ASSERT_SAME(a_query_bounds_ordered, clock, reset, q_walk, a_ff <= b_ff, "bounds crossed")
   `RMCT_ASSERT_SAME(a_query_no_ram_write, clock, reset, q_busy, !ram_we, "query wrote the tree")

endmodule
